// ===== hdl/msp_rx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msp_rx_pkg
// Shared types and constants for the response frame receiver.
// ----------------------------------------------------------------------------
package msp_rx_pkg;

    localparam logic [7:0] HDR_DOLLAR = 8'h24;
    localparam logic [7:0] HDR_M      = 8'h4D;
    localparam logic [7:0] HDR_GT     = 8'h3E;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic       out_kind;
        logic [7:0] command;
        logic [7:0] frame_size;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic       checksum_ok;
        logic       last;
    } t_result;

    typedef enum logic [6:0] {
        ST_HUNT    = 7'b0000001,
        ST_WANT_M  = 7'b0000010,
        ST_WANT_GT = 7'b0000100,
        ST_SIZE    = 7'b0001000,
        ST_CMD     = 7'b0010000,
        ST_PAYLOAD = 7'b0100000,
        ST_CHECK   = 7'b1000000
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/msp_rx_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msp_rx_front
// Frame parser: hunts for the header, tracks size, command, payload count and
// running XOR, and produces one result word per payload or checksum byte.
// ----------------------------------------------------------------------------
module msp_rx_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  wire [7:0]            i_rx_byte,
    output logic                 o_res_valid,
    output msp_rx_pkg::t_result  o_res
);
    import msp_rx_pkg::*;

    t_state     r_state, n_state;
    logic [7:0] r_size, n_size;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_count, n_count;
    logic [7:0] r_xor, n_xor;
    logic [7:0] count_inc;

    assign count_inc = r_count + 8'd1;

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_xor       = r_xor;
        o_res_valid = 1'b0;
        o_res.out_kind     = KIND_PAYLOAD;
        o_res.command      = r_cmd;
        o_res.frame_size   = r_size;
        o_res.payload_byte = 8'd0;
        o_res.byte_index   = 8'd0;
        o_res.checksum_ok  = 1'b0;
        o_res.last         = 1'b0;
        if (i_accept) begin
            unique case (r_state)
                ST_WANT_M: begin
                    n_state = (i_rx_byte == HDR_M) ? ST_WANT_GT : ST_HUNT;
                end
                ST_WANT_GT: begin
                    n_state = (i_rx_byte == HDR_GT) ? ST_SIZE : ST_HUNT;
                end
                ST_SIZE: begin
                    n_size  = i_rx_byte;
                    n_xor   = i_rx_byte;
                    n_state = ST_CMD;
                end
                ST_CMD: begin
                    n_cmd   = i_rx_byte;
                    n_xor   = r_xor ^ i_rx_byte;
                    n_count = 8'd0;
                    n_state = (r_size == 8'd0) ? ST_CHECK : ST_PAYLOAD;
                end
                ST_PAYLOAD: begin
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = i_rx_byte;
                    o_res.byte_index   = r_count;
                    n_xor   = r_xor ^ i_rx_byte;
                    n_count = count_inc;
                    if (count_inc == r_size) begin
                        n_state = ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    o_res_valid       = 1'b1;
                    o_res.out_kind    = KIND_END;
                    o_res.checksum_ok = (i_rx_byte == r_xor);
                    o_res.last        = 1'b1;
                    n_state = ST_HUNT;
                end
                default: begin
                    n_state = (i_rx_byte == HDR_DOLLAR) ? ST_WANT_M : ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_size  <= 8'd0;
            r_cmd   <= 8'd0;
            r_count <= 8'd0;
            r_xor   <= 8'd0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_cmd   <= n_cmd;
            r_count <= n_count;
            r_xor   <= n_xor;
        end
    end

    a_check_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_state == ST_CHECK) |=> (r_state == ST_HUNT))
        else $error("frame end did not return to hunting");

    a_count_below_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAYLOAD) |-> (r_count < r_size))
        else $error("payload count reached frame size");

    a_no_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_state) && $stable(r_xor))
        else $error("parser state moved without a word");

endmodule
`default_nettype wire

// ===== hdl/msp_rx_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msp_rx_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module msp_rx_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_wr_en,
    input  msp_rx_pkg::t_result  i_wr_data,
    input  wire                  i_rd_en,
    output msp_rx_pkg::t_result  o_rd_data,
    output logic                 o_full,
    output logic                 o_nonempty
);
    import msp_rx_pkg::*;

    t_result               r_mem [QDEPTH];
    logic [QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [QCOUNT_W-1:0]   r_count, n_count;

    assign o_full     = (r_count == QCOUNT_W'(QDEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + (i_wr_en ? QPTR_W'(1) : QPTR_W'(0));
        n_rd_ptr = r_rd_ptr + (i_rd_en ? QPTR_W'(1) : QPTR_W'(0));
        n_count  = r_count + (i_wr_en ? QCOUNT_W'(1) : QCOUNT_W'(0))
                           - (i_rd_en ? QCOUNT_W'(1) : QCOUNT_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr_en && o_full && !i_rd_en))
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en |-> o_nonempty)
        else $error("read from empty queue");

    a_count_tracks_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != QCOUNT_W'(QDEPTH)) |->
            (QPTR_W'(r_wr_ptr - r_rd_ptr) == QPTR_W'(r_count)))
        else $error("queue count out of step with pointers");

endmodule
`default_nettype wire

// ===== hdl/msp_rx_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msp_rx_back
// Output register: holds the oldest result word until it is popped and
// refills from the queue in the same cycle.
// ----------------------------------------------------------------------------
module msp_rx_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_q_nonempty,
    input  msp_rx_pkg::t_result  i_q_data,
    output logic                 o_q_rd,
    input  wire                  i_pop,
    output logic                 o_valid,
    output msp_rx_pkg::t_result  o_word
);
    import msp_rx_pkg::*;

    logic    r_valid, n_valid;
    t_result r_word;
    logic    take;

    assign take    = r_valid && i_pop;
    assign o_q_rd  = i_q_nonempty && (!r_valid || take);
    assign n_valid = o_q_rd || (r_valid && !take);
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_word <= i_q_data;
        end
    end

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> (r_valid && $stable(r_word)))
        else $error("output word changed while stalled");

    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_valid && i_q_nonempty) |=> r_valid)
        else $error("output stage did not refill from queue");

    a_end_word_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_word.last) |->
            (r_word.out_kind == KIND_END && r_word.payload_byte == 8'd0))
        else $error("malformed end-of-frame word");

endmodule
`default_nettype wire

// ===== hdl/msp_response_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msp_response_frame_receiver_unit
// Response frame receiver: header hunt, size/command capture, payload and
// checksum results through a result queue.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle whenever full is low. Header, size and
// command bytes produce nothing; each payload byte yields one word with its
// index, and the checksum byte yields an end word with the verdict. Results
// pass through a four-entry queue and an output register, so the word of a
// byte is registered in the queue and then in the output register before it
// reaches the result ports; the byte rate of one per cycle is set by the parser
// state machine, and full rises only when the queue and the output register are
// both occupied.
module msp_response_frame_receiver_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        push,
    output logic       full,
    input  wire [7:0]  i_rx_byte,
    output logic       empty,
    input  wire        pop,
    output logic       o_out_kind,
    output logic [7:0] o_command,
    output logic [7:0] o_frame_size,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_byte_index,
    output logic       o_checksum_ok,
    output logic       o_last
);
    import msp_rx_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    logic    q_full;
    logic    q_nonempty;
    logic    q_rd;
    t_result q_data;
    logic    out_valid;
    t_result out_word;

    assign full   = q_full;
    assign accept = push && !q_full;

    msp_rx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    msp_rx_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (res_valid),
        .i_wr_data  (res),
        .i_rd_en    (q_rd),
        .o_rd_data  (q_data),
        .o_full     (q_full),
        .o_nonempty (q_nonempty)
    );

    msp_rx_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_data     (q_data),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_valid      (out_valid),
        .o_word       (out_word)
    );

    assign empty          = !out_valid;
    assign o_out_kind     = out_word.out_kind;
    assign o_command      = out_word.command;
    assign o_frame_size   = out_word.frame_size;
    assign o_payload_byte = out_word.payload_byte;
    assign o_byte_index   = out_word.byte_index;
    assign o_checksum_ok  = out_word.checksum_ok;
    assign o_last         = out_word.last;

endmodule
`default_nettype wire
